>>> src/vfe_pkg.sv
// Package with the shared types and constants of the voxel exposed face emitter.
`timescale 1ns / 1ps
package vfe_pkg;

   localparam logic [1:0] CMD_WRITE_VOXEL = 2'd0;
   localparam logic [1:0] CMD_WRITE_BRUSH = 2'd1;
   localparam logic [1:0] CMD_EXAMINE     = 2'd2;
   localparam logic [1:0] CMD_END_PASS    = 2'd3;

   localparam logic [1:0] DIR_EAST  = 2'd0;
   localparam logic [1:0] DIR_WEST  = 2'd1;
   localparam logic [1:0] DIR_TOP   = 2'd2;
   localparam logic [1:0] DIR_SOUTH = 2'd3;

   localparam logic KIND_FACE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic       CSR_SELECT_LAYER = 1'b0;
   localparam logic       CSR_FACE_MODE    = 1'b1;
   localparam logic [7:0] UNKNOWN_TEX      = 8'hff;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EMIT,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] x;
      logic [3:0] y;
      logic [5:0] z;
      logic [7:0] brush;
      logic [7:0] tex_top_in;
      logic [7:0] tex_south_in;
      logic [7:0] tex_west_in;
      logic [7:0] tex_east_in;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  face_dir;
      logic [5:0]  cell_x;
      logic [3:0]  cell_y;
      logic [5:0]  cell_z;
      logic [7:0]  texture;
      logic [14:0] pick_id;
      logic [19:0] vertex_base;
      logic [14:0] select_count;
      logic        last;
   } rsp_type;

endpackage

>>> src/voxel_exposed_face_emitter.sv
// Top level of the voxel exposed face emitter.
//
// Requests arrive on req_valid/req_stall/req_data. Voxel writes and brush
// writes give no result. An examine request reads the cell and its east,
// west, top and south neighbors through the single read port of the grid
// memory, one read a cycle, then steps through the four directions in turn
// and hands out up to four face results on rsp_valid/rsp_stall/rsp_data. An
// end-pass request gives one summary result and clears the counters. The
// last result of a request has last set. Requests are taken only while the
// sequencer is idle.
// The result sits in an output register; while rsp_stall is high it holds and
// the sequencer waits before loading the next result.
// After reset the block clears the grid memory one cell a cycle
// (GRID_WIDTH*GRID_HEIGHT*GRID_DEPTH cells, 65536 at the defaults) and
// stalls requests meanwhile. Configuration writes take effect at once and
// belong only where no request is in flight.
`timescale 1ns / 1ps
module voxel_exposed_face_emitter #(
   parameter int GRID_WIDTH    = 64,
   parameter int GRID_HEIGHT   = 16,
   parameter int GRID_DEPTH    = 64,
   parameter int BRUSH_ENTRIES = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  vfe_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output vfe_pkg::rsp_type rsp_data,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [3:0]      csr_wdata
);
   import vfe_pkg::*;

   localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT * GRID_DEPTH;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int BR_W   = $clog2(BRUSH_ENTRIES);
   localparam int LAYER  = GRID_WIDTH * GRID_HEIGHT;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [2:0]  step_ff, step_in;
   logic [1:0]  dir_ff, dir_in;
   logic [5:0]  x_ff, x_in;
   logic [3:0]  y_ff, y_in;
   logic [5:0]  z_ff, z_in;
   logic        on_layer_ff, on_layer_in;
   logic        unknown_ff, unknown_in;
   logic [BR_W-1:0] br_raddr_ff, br_raddr_in;
   logic [31:0] entry_ff, entry_in;
   logic [3:0]  exp_ff, exp_in;
   logic [14:0] id_ff, id_in;
   logic [12:0] cube_ff, cube_in;
   logic [14:0] face_ff, face_in;
   logic [19:0] vert_ff, vert_in;
   logic [3:0]  layer_ff;
   logic        mode_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic              accept, out_free, center_in_grid;
   logic              vox_we, br_we, edge_hit;
   logic [ADDR_W-1:0] vox_waddr, vox_raddr;
   logic [7:0]        vox_wdata, vox_rdata;
   logic [31:0]       br_rdata, br_wdata;
   logic [31:0]       rx, ry, rz;
   logic [7:0]        vm1;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] cx,
         input logic [31:0] cy, input logic [31:0] cz);
      logic [31:0] sum;
      sum = cx + cy * GRID_WIDTH + cz * LAYER;
      return sum[ADDR_W-1:0];
   endfunction

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign center_in_grid = (32'(x_ff) < GRID_WIDTH) && (32'(y_ff) < GRID_HEIGHT)
                        && (32'(z_ff) < GRID_DEPTH);
   assign vm1 = vox_rdata - 8'd1;

   // Neighbor address for each fetch step: center, east, west, top, south.
   always_comb begin
      rx = 32'(x_ff);
      ry = 32'(y_ff);
      rz = 32'(z_ff);
      edge_hit = 1'b0;
      case (step_ff)
         3'd1: rx = 32'(x_ff) + 32'd1;
         3'd2: rx = 32'(x_ff) - 32'd1;
         3'd3: ry = 32'(y_ff) + 32'd1;
         3'd4: rz = 32'(z_ff) + 32'd1;
         default: ;
      endcase
      // Edge test for the neighbor whose data arrives in this step.
      case (step_ff)
         3'd2: edge_hit = (32'(x_ff) + 32'd1 >= GRID_WIDTH);
         3'd3: edge_hit = (x_ff == 6'd0);
         3'd4: edge_hit = (32'(y_ff) + 32'd1 >= GRID_HEIGHT);
         3'd5: edge_hit = (32'(z_ff) + 32'd1 >= GRID_DEPTH);
         default: edge_hit = 1'b0;
      endcase
   end

   always_comb begin
      vox_we    = 1'b0;
      vox_waddr = clr_addr_ff;
      vox_wdata = 8'd0;
      if (state_ff == ST_CLEAR) begin
         vox_we = 1'b1;
      end else if (accept && req_data.cmd == CMD_WRITE_VOXEL) begin
         vox_we = (32'(req_data.x) < GRID_WIDTH) && (32'(req_data.y) < GRID_HEIGHT)
               && (32'(req_data.z) < GRID_DEPTH);
         vox_waddr = cell_addr(32'(req_data.x), 32'(req_data.y), 32'(req_data.z));
         vox_wdata = req_data.brush;
      end
      vox_raddr = cell_addr(rx, ry, rz);
      br_we    = accept && req_data.cmd == CMD_WRITE_BRUSH
              && (32'(req_data.brush) < BRUSH_ENTRIES);
      br_wdata = {req_data.tex_east_in, req_data.tex_west_in,
                  req_data.tex_south_in, req_data.tex_top_in};
   end

   vfe_ram #(.WIDTH(8), .DEPTH(CELLS)) u_voxel_ram (
      .clock(clock), .we(vox_we), .waddr(vox_waddr), .wdata(vox_wdata),
      .raddr(vox_raddr), .rdata(vox_rdata)
   );

   vfe_ram #(.WIDTH(32), .DEPTH(BRUSH_ENTRIES)) u_brush_ram (
      .clock(clock), .we(br_we), .waddr(req_data.brush[BR_W-1:0]), .wdata(br_wdata),
      .raddr(br_raddr_ff), .rdata(br_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_addr_ff == ADDR_W'(CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_EXAMINE) state_in = ST_FETCH;
            else if (accept && req_data.cmd == CMD_END_PASS) state_in = ST_SUMMARY;
         end
         ST_FETCH: begin
            if (step_ff == 3'd1 && (!center_in_grid || vox_rdata == 8'd0)) begin
               state_in = ST_IDLE;
            end else if (step_ff == 3'd5) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: if (out_free && dir_ff == DIR_SOUTH) state_in = ST_IDLE;
         ST_SUMMARY: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and counters.
   always_comb begin
      clr_addr_in  = clr_addr_ff + ADDR_W'(1);
      step_in      = step_ff;
      dir_in       = dir_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      on_layer_in  = on_layer_ff;
      unknown_in   = unknown_ff;
      br_raddr_in  = br_raddr_ff;
      entry_in     = entry_ff;
      exp_in       = exp_ff;
      id_in        = id_ff;
      cube_in      = cube_ff;
      face_in      = face_ff;
      vert_in      = vert_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in     = 3'd0;
            dir_in      = DIR_EAST;
            x_in        = req_data.x;
            y_in        = req_data.y;
            z_in        = req_data.z;
            on_layer_in = (req_data.y == layer_ff);
            id_in       = 15'd0;
         end
         ST_FETCH: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd1) begin
               // Brush number b selects table entry b-1.
               unknown_in  = (vox_rdata == 8'd0) || (32'(vm1) >= BRUSH_ENTRIES);
               br_raddr_in = vm1[BR_W-1:0];
               if (center_in_grid && vox_rdata != 8'd0 && on_layer_ff && !mode_ff) begin
                  cube_in = cube_ff + 13'd1;
                  id_in   = 15'(cube_ff + 13'd1);
               end
            end
            if (step_ff == 3'd3) begin
               entry_in = unknown_ff ? {4{UNKNOWN_TEX}} : br_rdata;
            end
            if (step_ff >= 3'd2) begin
               exp_in[step_ff[1:0] - 2'd2] = edge_hit || (vox_rdata == 8'd0);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               dir_in = dir_ff + 2'd1;
               if (exp_ff[dir_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_data_in.kind     = KIND_FACE;
                  rsp_data_in.face_dir = dir_ff;
                  rsp_data_in.cell_x   = x_ff;
                  rsp_data_in.cell_y   = y_ff;
                  rsp_data_in.cell_z   = z_ff;
                  case (dir_ff)
                     DIR_EAST:  rsp_data_in.texture = entry_ff[31:24];
                     DIR_WEST:  rsp_data_in.texture = entry_ff[23:16];
                     DIR_TOP:   rsp_data_in.texture = entry_ff[7:0];
                     DIR_SOUTH: rsp_data_in.texture = entry_ff[15:8];
                     default:   rsp_data_in.texture = entry_ff[7:0];
                  endcase
                  rsp_data_in.pick_id = id_ff;
                  if (on_layer_ff && mode_ff) begin
                     face_in = face_ff + 15'd1;
                     id_in   = face_ff + 15'd1;
                     rsp_data_in.pick_id = face_ff + 15'd1;
                  end
                  rsp_data_in.vertex_base = vert_ff;
                  vert_in = vert_ff + 20'd4;
                  rsp_data_in.last = ((exp_ff >> (3'(dir_ff) + 3'd1)) == 4'd0);
               end
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.kind = KIND_SUMMARY;
               rsp_data_in.select_count = mode_ff ? face_ff : 15'(cube_ff);
               rsp_data_in.last = 1'b1;
               cube_in = 13'd0;
               face_in = 15'd0;
               vert_in = 20'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= 3'd0;
         dir_ff       <= DIR_EAST;
         cube_ff      <= 13'd0;
         face_ff      <= 15'd0;
         vert_ff      <= 20'd0;
         layer_ff     <= 4'd0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         dir_ff       <= dir_in;
         cube_ff      <= cube_in;
         face_ff      <= face_in;
         vert_ff      <= vert_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_SELECT_LAYER) layer_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_FACE_MODE) mode_ff <= csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      on_layer_ff <= on_layer_in;
      unknown_ff  <= unknown_in;
      br_raddr_ff <= br_raddr_in;
      entry_ff    <= entry_in;
      exp_ff      <= exp_in;
      id_ff       <= id_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

>>> src/vfe_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module vfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/vfe_checker.sv
// Port level checks of the voxel exposed face emitter and their binding.
`timescale 1ns / 1ps
module vfe_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input vfe_pkg::rsp_type rsp_data
);
   import vfe_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_SUMMARY |->
         rsp_data.last && rsp_data.pick_id == 15'd0 && rsp_data.vertex_base == 20'd0)
      else $error("malformed summary");

   a_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FACE |-> rsp_data.select_count == 15'd0)
      else $error("face record carries a count");
endmodule

bind voxel_exposed_face_emitter vfe_port_checks u_vfe_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
